// ----- rtl/gtr_pkg.sv -----
package gtr_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 2'd1;

    localparam logic [7:0] CODE_FIRST_PRINT = 8'h20;
    localparam logic [7:0] CODE_HIGH_PAGE   = 8'h90;
    localparam logic [7:0] CODE_HIGH_OFFSET = 8'h60;
    localparam logic [7:0] CURSOR_ADVANCE   = 8'd6;
    localparam logic [7:0] FG_RESET         = 8'hff;
    localparam logic [7:0] BG_RESET         = 8'h00;

    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 8;
    localparam int GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;
    localparam int FONT_STORED = 160;
    localparam logic [2:0] LAST_COL = 3'(GLYPH_COLS - 1);
    localparam logic [2:0] LAST_ROW = 3'(GLYPH_ROWS - 1);

    typedef struct packed {
        logic [7:0] char_code;
        logic       begin_string;
        logic [7:0] start_x;
        logic [7:0] start_y;
    } t_char_in;

    typedef struct packed {
        logic [7:0] pix_x;
        logic [7:0] pix_y;
        logic [7:0] pix_color;
        logic       last_pixel;
    } t_pix_out;

    typedef struct packed {
        logic accept;
        logic step;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic draw;
        logic last;
    } t_dp_status;

    // column c of the glyph sits in bits [8c+7:8c], row 0 in the lsb
    function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [7:0] g);
        logic [GLYPH_BITS-1:0] w;
        unique case (g)
            8'd0:   w = 40'h0000000000;  8'd1:   w = 40'h00004f0000;
            8'd2:   w = 40'h0007000700;  8'd3:   w = 40'h147f147f14;
            8'd4:   w = 40'h122a7f2a24;  8'd5:   w = 40'h6264081323;
            8'd6:   w = 40'h4022554936;  8'd7:   w = 40'h0000030500;
            8'd8:   w = 40'h0041221c00;  8'd9:   w = 40'h001c224100;
            8'd10:  w = 40'h14083e0814;  8'd11:  w = 40'h08083e0808;
            8'd12:  w = 40'h0000305000;  8'd13:  w = 40'h0808080808;
            8'd14:  w = 40'h0000606000;  8'd15:  w = 40'h0204081020;
            8'd16:  w = 40'h3e4549513e;  8'd17:  w = 40'h00407f4200;
            8'd18:  w = 40'h4649516142;  8'd19:  w = 40'h314b454121;
            8'd20:  w = 40'h107f121418;  8'd21:  w = 40'h3945454527;
            8'd22:  w = 40'h3049494a3c;  8'd23:  w = 40'h0305097101;
            8'd24:  w = 40'h3649494936;  8'd25:  w = 40'h1e29494906;
            8'd26:  w = 40'h0000363600;  8'd27:  w = 40'h0000365600;
            8'd28:  w = 40'h0041221408;  8'd29:  w = 40'h1414141414;
            8'd30:  w = 40'h0814224100;  8'd31:  w = 40'h0609510102;
            8'd32:  w = 40'h3e41714932;  8'd33:  w = 40'h7e1111117e;
            8'd34:  w = 40'h364949497f;  8'd35:  w = 40'h224141413e;
            8'd36:  w = 40'h1c2241417f;  8'd37:  w = 40'h414949497f;
            8'd38:  w = 40'h010909097f;  8'd39:  w = 40'h3a4949413e;
            8'd40:  w = 40'h7f0808087f;  8'd41:  w = 40'h00417f4100;
            8'd42:  w = 40'h013f414020;  8'd43:  w = 40'h412214087f;
            8'd44:  w = 40'h404040407f;  8'd45:  w = 40'h7f020c027f;
            8'd46:  w = 40'h7f1008047f;  8'd47:  w = 40'h3e4141413e;
            8'd48:  w = 40'h060909097f;  8'd49:  w = 40'h5e2151413e;
            8'd50:  w = 40'h462919097f;  8'd51:  w = 40'h3149494946;
            8'd52:  w = 40'h01017f0101;  8'd53:  w = 40'h3f4040403f;
            8'd54:  w = 40'h1f2040201f;  8'd55:  w = 40'h3f4030403f;
            8'd56:  w = 40'h6314081463;  8'd57:  w = 40'h0708700807;
            8'd58:  w = 40'h4345495161;  8'd59:  w = 40'h0041417f00;
            8'd60:  w = 40'h2010080402;  8'd61:  w = 40'h007f414100;
            8'd62:  w = 40'h0402010204;  8'd63:  w = 40'h4040404040;
            8'd64:  w = 40'h0004020100;  8'd65:  w = 40'h7854545420;
            8'd66:  w = 40'h384444487f;  8'd67:  w = 40'h2044444438;
            8'd68:  w = 40'h7f48444438;  8'd69:  w = 40'h1854545438;
            8'd70:  w = 40'h0201097e08;  8'd71:  w = 40'h3e5252520c;
            8'd72:  w = 40'h780404087f;  8'd73:  w = 40'h00407d4400;
            8'd74:  w = 40'h003d444020;  8'd75:  w = 40'h004428107f;
            8'd76:  w = 40'h00407f4100;  8'd77:  w = 40'h780418047c;
            8'd78:  w = 40'h780404087c;  8'd79:  w = 40'h3844444438;
            8'd80:  w = 40'h081414147c;  8'd81:  w = 40'h7c18141408;
            8'd82:  w = 40'h080404087c;  8'd83:  w = 40'h2054545448;
            8'd84:  w = 40'h2040443f04;  8'd85:  w = 40'h7c2040403c;
            8'd86:  w = 40'h1c2040201c;  8'd87:  w = 40'h3c4030403c;
            8'd88:  w = 40'h4428102844;  8'd89:  w = 40'h3c5050500c;
            8'd90:  w = 40'h444c546444;  8'd91:  w = 40'h0041360800;
            8'd92:  w = 40'h00007f0000;  8'd93:  w = 40'h0008364100;
            8'd94:  w = 40'h0102020102;  8'd95:  w = 40'h0000000000;
            8'd96:  w = 40'h7e1111117e;  8'd97:  w = 40'h334949497f;
            8'd98:  w = 40'h364949497f;  8'd99:  w = 40'h030101017f;
            8'd100: w = 40'hff414f51e0;  8'd101: w = 40'h414949497f;
            8'd102: w = 40'h77087f0877;  8'd103: w = 40'h3649494941;
            8'd104: w = 40'h7f0408107f;  8'd105: w = 40'h7c0912217c;
            8'd106: w = 40'h412214087f;  8'd107: w = 40'h7f013f4120;
            8'd108: w = 40'h7f020c027f;  8'd109: w = 40'h7f0808087f;
            8'd110: w = 40'h3e4141413e;  8'd111: w = 40'h7f0101017f;
            8'd112: w = 40'h060909097f;  8'd113: w = 40'h224141413e;
            8'd114: w = 40'h01017f0101;  8'd115: w = 40'h0708102847;
            8'd116: w = 40'h1c227f221c;  8'd117: w = 40'h6314081463;
            8'd118: w = 40'hff4040407f;  8'd119: w = 40'h7f08080807;
            8'd120: w = 40'h7f407f407f;  8'd121: w = 40'hff407f407f;
            8'd122: w = 40'h3048487f01;  8'd123: w = 40'h7f0030487f;
            8'd124: w = 40'h3048487f00;  8'd125: w = 40'h3e49494122;
            8'd126: w = 40'h3e413e087f;  8'd127: w = 40'h7f09192946;
            8'd128: w = 40'h7854545420;  8'd129: w = 40'h31494a4a3c;
            8'd130: w = 40'h002854547c;  8'd131: w = 40'h0c0404047c;
            8'd132: w = 40'hfc444c54e0;  8'd133: w = 40'h1854545438;
            8'd134: w = 40'h6c107c106c;  8'd135: w = 40'h2854544444;
            8'd136: w = 40'h7c0810207c;  8'd137: w = 40'h7c1122417c;
            8'd138: w = 40'h004428107c;  8'd139: w = 40'h7c043c4420;
            8'd140: w = 40'h7c0810087c;  8'd141: w = 40'h7c1010107c;
            8'd142: w = 40'h3844444438;  8'd143: w = 40'h7c0404047c;
            8'd144: w = 40'h081414147c;  8'd145: w = 40'h2044444438;
            8'd146: w = 40'h04047c0404;  8'd147: w = 40'h3c5050500c;
            8'd148: w = 40'h3048fc4830;  8'd149: w = 40'h4428102844;
            8'd150: w = 40'hfc4040407c;  8'd151: w = 40'h7c1010100c;
            8'd152: w = 40'h7c407c407c;  8'd153: w = 40'hfc407c407c;
            8'd154: w = 40'h2050507c04;  8'd155: w = 40'h7c2050507c;
            8'd156: w = 40'h002050507c;  8'd157: w = 40'h3854544428;
            8'd158: w = 40'h384438107c;  8'd159: w = 40'h7c14345408;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/gtr_ctrl.sv -----
module gtr_ctrl
    import gtr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DRAW = 1'b1;

    logic r_state;
    logic n_state;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_DRAW);

    assign o_cmd.accept = i_in_valid && o_in_ready;
    assign o_cmd.step   = o_out_valid && i_out_ready;
    assign o_cmd.finish = o_cmd.step && i_status.last;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.accept && i_status.draw) begin
                    n_state = ST_DRAW;
                end
            end
            ST_DRAW: begin
                if (o_cmd.finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_finish_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_state == ST_IDLE)
        else $error("controller stayed busy after the last pixel");

    a_no_draw_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && !i_status.draw) |=> r_state == ST_IDLE)
        else $error("controller started drawing a character with no pixels");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && !o_in_ready)
        else $error("pixel dropped while the receiver stalled");

endmodule

// ----- rtl/gtr_dpath.sv -----
module gtr_dpath
    import gtr_pkg::*;
#(
    parameter int GLYPH_COUNT = 160,
    parameter int ROW_LIMIT   = 232,
    parameter int COL_LIMIT   = 244
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl_cmd            i_cmd,
    input  t_char_in             i_in_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    output t_dp_status           o_status,
    output t_pix_out             o_out_data
);

    logic [7:0]            r_cursor_x;
    logic [7:0]            r_cursor_y;
    logic                  r_active;
    logic [7:0]            r_fg;
    logic [7:0]            r_bg;
    logic [GLYPH_BITS-1:0] r_glyph;
    logic [2:0]            r_col;
    logic [2:0]            r_row;

    logic [7:0] eff_x;
    logic [7:0] eff_y;
    logic       eff_active;
    logic       stop;
    logic [7:0] glyph_idx;
    logic       glyph_ok;
    logic       bit_set;

    assign eff_x      = i_in_data.begin_string ? i_in_data.start_x : r_cursor_x;
    assign eff_y      = i_in_data.begin_string ? i_in_data.start_y : r_cursor_y;
    assign eff_active = i_in_data.begin_string || r_active;

    assign stop = (i_in_data.char_code < CODE_FIRST_PRINT)
               || ({1'b0, eff_y} >= 9'(ROW_LIMIT))
               || ({1'b0, eff_x} >= 9'(COL_LIMIT));

    assign glyph_idx = (i_in_data.char_code < CODE_HIGH_PAGE)
                     ? i_in_data.char_code - CODE_FIRST_PRINT
                     : i_in_data.char_code - CODE_HIGH_OFFSET;
    assign glyph_ok  = ({1'b0, glyph_idx} < 9'(GLYPH_COUNT))
                    && ({1'b0, glyph_idx} < 9'(FONT_STORED));

    assign o_status.draw = eff_active && !stop;
    assign o_status.last = (r_col == LAST_COL) && (r_row == LAST_ROW);

    assign bit_set              = r_glyph[{r_col, r_row}];
    assign o_out_data.pix_x      = r_cursor_x + {5'd0, r_col};
    assign o_out_data.pix_y      = r_cursor_y + {5'd0, r_row};
    assign o_out_data.pix_color  = bit_set ? r_fg : r_bg;
    assign o_out_data.last_pixel = o_status.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x <= '0;
            r_cursor_y <= '0;
            r_active   <= 1'b0;
            r_fg       <= FG_RESET;
            r_bg       <= BG_RESET;
            r_col      <= '0;
            r_row      <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FG_COLOR) begin
                    r_fg <= i_cfg_data;
                end else if (i_cfg_index == CFG_BG_COLOR) begin
                    r_bg <= i_cfg_data;
                end
            end
            if (i_cmd.accept) begin
                if (eff_active) begin
                    r_cursor_x <= eff_x;
                    r_cursor_y <= eff_y;
                    r_active   <= !stop;
                end
                r_col <= '0;
                r_row <= '0;
            end else if (i_cmd.finish) begin
                r_cursor_x <= r_cursor_x + CURSOR_ADVANCE;
                r_col      <= '0;
                r_row      <= '0;
            end else if (i_cmd.step) begin
                if (r_row == LAST_ROW) begin
                    r_row <= '0;
                    r_col <= r_col + 3'd1;
                end else begin
                    r_row <= r_row + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_glyph <= glyph_ok ? glyph_bits(glyph_idx) : '0;
        end
    end

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= LAST_COL)
        else $error("column counter ran past the glyph");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_cursor_x == 8'($past(r_cursor_x) + CURSOR_ADVANCE))
        else $error("cursor did not advance after a character");

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && stop) |=> !r_active)
        else $error("string still active after an end condition");

endmodule

// ----- rtl/glyph_text_rasterizer.sv -----
// 5x8 bitmap font text renderer
// input channel (i_in_valid / o_in_ready / i_in_data): one character per
// transaction; begin_string loads the cursor from start_x/start_y and opens
// a string. control codes, or a cursor at or past the row or column limit, close
// the string and draw nothing; codes outside an open string are dropped.
// output channel (o_out_valid / i_out_ready / o_out_data): 40 pixel writes
// per drawn character, column by column, 8 rows each, top row first;
// last_pixel marks the fortieth. colours come from the cfg write channel
// (index 0 foreground, index 1 background); they must be written only while
// idle, which the block itself does not enforce. the first pixel comes in the
// cycle after the character is taken, then one pixel per cycle while the
// receiver takes them; a character that draws nothing is taken without
// leaving idle.
// a stalled receiver holds the current pixel and the block takes no new
// character until the last pixel has gone.
// reset: cursor at 0,0, no string open, foreground 255, background 0.
module glyph_text_rasterizer
    import gtr_pkg::*;
#(
    parameter int GLYPH_COUNT = 160,
    parameter int ROW_LIMIT   = 232,
    parameter int COL_LIMIT   = 244
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_char_in             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_pix_out             o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    gtr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    gtr_dpath #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .ROW_LIMIT   (ROW_LIMIT),
        .COL_LIMIT   (COL_LIMIT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_status    (status),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- tb/glyph_text_rasterizer_tb.sv -----
module glyph_text_rasterizer_tb;
    import gtr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GLYPH_COUNT = 160;
    localparam int ROW_LIMIT   = 232;
    localparam int COL_LIMIT   = 244;
    localparam int DRAW_CYCLES = 45;
    localparam int MAX_REPORTS = 10;

    // indexes past the two colour registers, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic [7:0] CODE_NUL   = 8'h00;
    localparam logic [7:0] CODE_US    = 8'h1f;
    localparam logic [7:0] CODE_SPACE = 8'h20;

    // one word per glyph, column 0 in the top byte, row 0 in the lsb of each byte
    localparam logic [39:0] FONT_ROM [FONT_STORED] = '{
        40'h0000000000, 40'h00004f0000, 40'h0007000700, 40'h147f147f14,
        40'h242a7f2a12, 40'h2313086462, 40'h3649552240, 40'h0005030000,
        40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
        40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
        40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324971413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
        40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149493a,
        40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
        40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
        40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
        40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4030403f,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
        40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
        40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
        40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
        40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
        40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
        40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
        40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
        40'h00007f0000, 40'h0041360800, 40'h0201020201, 40'h0000000000,
        40'h7e1111117e, 40'h7f49494933, 40'h7f49494936, 40'h7f01010103,
        40'he0514f41ff, 40'h7f49494941, 40'h77087f0877, 40'h4149494936,
        40'h7f1008047f, 40'h7c2112097c, 40'h7f08142241, 40'h20413f017f,
        40'h7f020c027f, 40'h7f0808087f, 40'h3e4141413e, 40'h7f0101017f,
        40'h7f09090906, 40'h3e41414122, 40'h01017f0101, 40'h4728100807,
        40'h1c227f221c, 40'h6314081463, 40'h7f404040ff, 40'h070808087f,
        40'h7f407f407f, 40'h7f407f40ff, 40'h017f484830, 40'h7f4830007f,
        40'h007f484830, 40'h224149493e, 40'h7f083e413e, 40'h462919097f,
        40'h2054545478, 40'h3c4a4a4931, 40'h7c54542800, 40'h7c0404040c,
        40'he0544c44fc, 40'h3854545418, 40'h6c107c106c, 40'h4444545428,
        40'h7c2010087c, 40'h7c4122117c, 40'h7c10284400, 40'h20443c047c,
        40'h7c0810087c, 40'h7c1010107c, 40'h3844444438, 40'h7c0404047c,
        40'h7c14141408, 40'h3844444420, 40'h04047c0404, 40'h0c5050503c,
        40'h3048fc4830, 40'h4428102844, 40'h7c404040fc, 40'h0c1010107c,
        40'h7c407c407c, 40'h7c407c40fc, 40'h047c505020, 40'h7c5050207c,
        40'h7c50502000, 40'h2844545438, 40'h7c10384438, 40'h085434147c
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_char_in             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_pix_out             o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;

    glyph_text_rasterizer #(
        .GLYPH_COUNT(GLYPH_COUNT),
        .ROW_LIMIT  (ROW_LIMIT),
        .COL_LIMIT  (COL_LIMIT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predicted block state
    logic [7:0] fg_colour;
    logic [7:0] bg_colour;
    logic [7:0] cursor_x;
    logic [7:0] cursor_y;
    logic       string_open;
    t_pix_out   pixel_q [$];

    int errors         = 0;
    int drawn_chars    = 0;
    int strings_closed = 0;
    int pixels_checked = 0;
    int colour_writes  = 0;
    int in_idle_pct    = 16;
    int out_stall_pct  = 16;

    function automatic void rasterize_char(input t_char_in c);
        logic [7:0]  glyph;
        logic [39:0] bits;
        logic [7:0]  col_byte;
        t_pix_out    px;
        if (c.begin_string) begin
            cursor_x    = c.start_x;
            cursor_y    = c.start_y;
            string_open = 1'b1;
        end
        if (!string_open)
            return;
        if (c.char_code < CODE_FIRST_PRINT || cursor_y >= ROW_LIMIT
            || cursor_x >= COL_LIMIT) begin
            string_open = 1'b0;
            strings_closed++;
            return;
        end
        glyph = (c.char_code < CODE_HIGH_PAGE) ? c.char_code - CODE_FIRST_PRINT
                                               : c.char_code - CODE_HIGH_OFFSET;
        bits = (glyph < GLYPH_COUNT && glyph < FONT_STORED) ? FONT_ROM[glyph] : '0;
        for (int col = 0; col < GLYPH_COLS; col++) begin
            col_byte = bits[39 - 8 * col -: 8];
            for (int row = 0; row < GLYPH_ROWS; row++) begin
                px.pix_x      = cursor_x + 8'(col);
                px.pix_y      = cursor_y + 8'(row);
                px.pix_color  = col_byte[row] ? fg_colour : bg_colour;
                px.last_pixel = (col == GLYPH_COLS - 1) && (row == GLYPH_ROWS - 1);
                pixel_q.push_back(px);
            end
        end
        cursor_x = cursor_x + CURSOR_ADVANCE;
        drawn_chars++;
    endfunction

    // one process for all three channels, so prediction and checking at an edge
    // happen in a fixed order
    always @(posedge i_clk) begin
        t_pix_out want;
        if (!i_rst_n) begin
            fg_colour   = FG_RESET;
            bg_colour   = BG_RESET;
            cursor_x    = '0;
            cursor_y    = '0;
            string_open = 1'b0;
            pixel_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FG_COLOR: fg_colour = i_cfg_data;
                    CFG_BG_COLOR: bg_colour = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready)
                rasterize_char(i_in_data);
            if (o_out_valid && i_out_ready) begin
                if (pixel_q.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected pixel x=%h y=%h colour=%h last=%b", $realtime,
                                 o_out_data.pix_x, o_out_data.pix_y, o_out_data.pix_color,
                                 o_out_data.last_pixel);
                end else begin
                    want = pixel_q.pop_front();
                    pixels_checked++;
                    if (o_out_data.pix_x !== want.pix_x || o_out_data.pix_y !== want.pix_y ||
                        o_out_data.pix_color !== want.pix_color ||
                        o_out_data.last_pixel !== want.last_pixel) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display({"%0t: pixel mismatch exp x=%h y=%h colour=%h last=%b,",
                                      " got x=%h y=%h colour=%h last=%b"},
                                     $realtime, want.pix_x, want.pix_y, want.pix_color,
                                     want.last_pixel, o_out_data.pix_x, o_out_data.pix_y,
                                     o_out_data.pix_color, o_out_data.last_pixel);
                    end
                end
            end
        end
    end

    always @(negedge i_clk)
        i_out_ready = ($urandom_range(99) >= out_stall_pct);

    task automatic send_char(input logic [7:0] code, input logic open_str,
                             input logic [7:0] sx, input logic [7:0] sy);
        int gap;
        @(negedge i_clk);
        // occasional gaps of random length so they land on every phase of a glyph
        if ($urandom_range(99) < in_idle_pct) begin
            gap = $urandom_range(60, 1);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = '{char_code: code, begin_string: open_str, start_x: sx, start_y: sy};
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (DRAW_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_colour(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        colour_writes++;
    endtask

    task automatic send_random_string();
        int         len;
        logic [7:0] sx;
        logic [7:0] sy;
        logic [7:0] code;
        sx  = ($urandom_range(99) < 85) ? 8'($urandom_range(COL_LIMIT - 1))
                                        : 8'($urandom_range(255, COL_LIMIT));
        sy  = ($urandom_range(99) < 85) ? 8'($urandom_range(ROW_LIMIT - 1))
                                        : 8'($urandom_range(255, ROW_LIMIT));
        len = $urandom_range(14, 1);
        for (int i = 0; i < len; i++) begin
            code = ($urandom_range(99) < 6) ? 8'($urandom_range(CODE_US))
                                            : 8'($urandom_range(255, CODE_SPACE));
            if (i == 0)
                send_char(code, 1'b1, sx, sy);
            else
                send_char(code, 1'b0, 8'($urandom), 8'($urandom));
        end
        if ($urandom_range(99) < 40)
            send_char(8'($urandom_range(CODE_US)), 1'b0, 8'($urandom), 8'($urandom));
        // noise: anything at all, often with no string open
        if ($urandom_range(99) < 15)
            send_char(8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic test_directed_glyphs();
        send_char(8'h41, 1'b0, 8'd0, 8'd0);         // nothing open yet, dropped
        send_char(CODE_SPACE, 1'b1, 8'd0, 8'd0);
        send_char(8'h7e, 1'b0, 8'd0, 8'd0);
        send_char(8'h7f, 1'b0, 8'd0, 8'd0);
        send_char(8'h8f, 1'b0, 8'hff, 8'hff);       // last code of the low page
        send_char(CODE_HIGH_PAGE, 1'b0, 8'd0, 8'd0);
        send_char(8'hff, 1'b0, 8'd0, 8'd0);
        send_char(8'h80, 1'b0, 8'd0, 8'd0);
        send_char(CODE_US, 1'b0, 8'd0, 8'd0);       // control code closes the string
        send_char(8'h42, 1'b0, 8'd0, 8'd0);
        send_char(8'h41, 1'b1, 8'(COL_LIMIT - 1), 8'(ROW_LIMIT - 1));
        send_char(8'h42, 1'b0, 8'd0, 8'd0);         // cursor now past the column limit
        send_char(8'h41, 1'b1, 8'(COL_LIMIT), 8'd0);
        send_char(8'h41, 1'b1, 8'd0, 8'(ROW_LIMIT));
        send_char(8'hff, 1'b1, 8'hff, 8'hff);
        send_char(CODE_NUL, 1'b1, 8'd10, 8'd10);    // load then close at once
        send_char(8'h48, 1'b1, 8'd100, 8'd100);
        send_char(8'h49, 1'b1, 8'd0, 8'd0);         // restart inside an open string
        send_char(8'h5a, 1'b0, 8'h55, 8'haa);
        send_char(8'hc1, 1'b0, 8'haa, 8'h55);
        wait_idle();
    endtask

    task automatic test_colour_settings();
        write_colour(CFG_FG_COLOR, 8'h00);
        write_colour(CFG_BG_COLOR, 8'hff);
        send_char(8'h57, 1'b1, 8'd20, 8'd30);
        send_char(8'h9f, 1'b0, 8'd0, 8'd0);
        wait_idle();
        write_colour(CFG_FG_COLOR, 8'h5a);
        write_colour(CFG_BG_COLOR, 8'h5a);
        write_colour(CFG_SPARE_A, 8'($urandom));
        write_colour(CFG_SPARE_B, 8'($urandom));
        send_char(8'h23, 1'b1, 8'd50, 8'd60);
        send_char(8'h40, 1'b0, 8'd0, 8'd0);
        wait_idle();
        write_colour(CFG_SPARE_A, 8'h00);
        write_colour(CFG_SPARE_B, 8'hff);
        write_colour(CFG_FG_COLOR, 8'hff);
        write_colour(CFG_BG_COLOR, 8'h00);
        send_char(8'h26, 1'b1, 8'd200, 8'd200);
        send_char(8'hb4, 1'b0, 8'd0, 8'd0);
        wait_idle();
    endtask

    task automatic test_random_text();
        int goal;
        for (int round = 0; round < 4; round++) begin
            write_colour(CFG_FG_COLOR, 8'($urandom));
            write_colour(CFG_BG_COLOR, 8'($urandom));
            goal = drawn_chars + 30;
            while (drawn_chars < goal)
                send_random_string();
            wait_idle();
        end
    endtask

    task automatic test_full_rate();
        int goal;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        write_colour(CFG_FG_COLOR, 8'h81);
        write_colour(CFG_BG_COLOR, 8'h7e);
        goal = drawn_chars + 25;
        while (drawn_chars < goal)
            send_random_string();
        wait_idle();
        in_idle_pct   = 16;
        out_stall_pct = 16;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_FG_COLOR;
        i_cfg_data  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_glyphs();
        test_colour_settings();
        test_random_text();
        test_full_rate();

        if (pixel_q.size() != 0) begin
            errors += pixel_q.size();
            $display("%0d expected pixels never arrived", pixel_q.size());
        end
        $display("drew %0d characters, checked %0d pixel writes, %0d strings closed",
                 drawn_chars, pixels_checked, strings_closed);
        $display("%0d colour register writes, %0d failures", colour_writes, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("timeout with %0d pixels outstanding", pixel_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
